>>> design/ncd_pkg.sv
// Shared constants, types and pipeline depths for the normal CDF pipeline.
package ncd_pkg;

    localparam logic [63:0] C_FULL =
        (64'd2316419 * 64'd4294967296 + 64'd5000000) / 64'd10000000;
    localparam logic [29:0] C_Q32 = C_FULL[29:0];

    localparam logic [63:0] A1_MAG =
        (64'd31938153 * 64'd1073741824 + 64'd50000000) / 64'd100000000;
    localparam logic [63:0] A2_MAG =
        (64'd356563782 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] A3_MAG =
        (64'd1781477937 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] A4_MAG =
        (64'd1821255978 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] A5_MAG =
        (64'd1330274429 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;

    localparam logic signed [32:0] A1_Q30 = $signed({1'b0, A1_MAG[31:0]});
    localparam logic signed [32:0] A2_Q30 = 33'sd0 - $signed({1'b0, A2_MAG[31:0]});
    localparam logic signed [32:0] A3_Q30 = $signed({1'b0, A3_MAG[31:0]});
    localparam logic signed [32:0] A4_Q30 = 33'sd0 - $signed({1'b0, A4_MAG[31:0]});
    localparam logic signed [32:0] A5_Q30 = $signed({1'b0, A5_MAG[31:0]});

    localparam int unsigned HORNER_STEPS = 5;
    // coefficient added after each Horner product; the last step adds nothing
    localparam logic signed [32:0] HORNER_ADD [1:HORNER_STEPS] =
        '{A4_Q30, A3_Q30, A2_Q30, A1_Q30, 33'sd0};

    localparam logic [63:0] INVSQRT_FULL =
        (64'd3989422804 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000;
    localparam logic [31:0] INVSQRT2PI_Q32 = INVSQRT_FULL[31:0];

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [63:0] NDIV_FULL = (64'd1 << 56) / 64'd2977044472;
    localparam logic [24:0] NDIV_M = NDIV_FULL[24:0];

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    localparam int unsigned EXP_TERMS = 13;
    localparam logic [63:0] R33 = 64'd1 << 33;
    localparam logic [63:0] EXP_RECIP_FULL [1:EXP_TERMS] = '{
        R33 / 64'd1,  R33 / 64'd2,  R33 / 64'd3,  R33 / 64'd4,  R33 / 64'd5,
        R33 / 64'd6,  R33 / 64'd7,  R33 / 64'd8,  R33 / 64'd9,  R33 / 64'd10,
        R33 / 64'd11, R33 / 64'd12, R33 / 64'd13};

    localparam int unsigned DIV_STEPS = 31;

    localparam int unsigned RECIP_LAT = 34;
    localparam int unsigned POLY_LAT  = 11;
    localparam int unsigned EXP_LAT   = 47;
    localparam int unsigned TAIL_LAT  = 4;
    localparam int unsigned NCD_LAT   = RECIP_LAT + POLY_LAT + EXP_LAT + TAIL_LAT;

    typedef struct packed {
        logic        neg;
        logic        far;
        logic [28:0] mag;
    } ncd_side_t;

endpackage

>>> design/ncd_recip.sv
// Argument magnitude, denominator and pipelined restoring reciprocal K = 2^60 / D.
module ncd_recip import ncd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] x,
    output logic               out_valid,
    output logic [30:0]        k30,
    output ncd_side_t          out_side
);

    logic [32:0] mag_full;
    logic        v1_reg;
    ncd_side_t   s1_reg;
    logic        v2_reg;
    ncd_side_t   s2_reg;
    logic [58:0] cl_reg;
    logic [59:0] dsum;
    logic [31:0] dval;

    logic        dv_reg  [0:DIV_STEPS];
    logic [31:0] d_reg   [0:DIV_STEPS];
    logic [31:0] rem_reg [0:DIV_STEPS];
    logic [30:0] low_reg [0:DIV_STEPS];
    logic [30:0] q_reg   [0:DIV_STEPS];
    ncd_side_t   sd_reg  [0:DIV_STEPS];

    assign mag_full = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};

    // D = 1 + c*L in Q.30, rounded
    assign dsum = {2'b01, 58'd0} + {1'b0, cl_reg} + (60'd1 << 27);
    assign dval = dsum[59:28];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg.neg <= x[31];
        s1_reg.far <= (mag_full[32:29] != 4'd0);
        s1_reg.mag <= mag_full[28:0];
        s2_reg     <= s1_reg;
        cl_reg     <= 59'(C_Q32) * 59'(s1_reg.mag);
        // numerator 2^60 + D/2: top part is 2^29, the rest shifts in bit by bit
        d_reg[0]   <= dval;
        rem_reg[0] <= 32'd1 << 29;
        low_reg[0] <= dval[31:1];
        q_reg[0]   <= '0;
        sd_reg[0]  <= s2_reg;
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [32:0] trial;
        logic [33:0] diff;
        logic        ge;

        assign trial = {rem_reg[j-1], low_reg[j-1][30]};
        assign diff  = {1'b0, trial} - {2'b00, d_reg[j-1]};
        assign ge    = !diff[33];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? diff[31:0] : trial[31:0];
            q_reg[j]   <= {q_reg[j-1][29:0], ge};
            low_reg[j] <= {low_reg[j-1][29:0], 1'b0};
            d_reg[j]   <= d_reg[j-1];
            sd_reg[j]  <= sd_reg[j-1];
        end
    end

    assign out_valid = dv_reg[DIV_STEPS];
    assign k30       = q_reg[DIV_STEPS];
    assign out_side  = sd_reg[DIV_STEPS];

endmodule

>>> design/ncd_poly.sv
// Five-step Horner pipeline for the polynomial in K, one multiply and one add stage per step.
module ncd_poly import ncd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [30:0] k30,
    input  ncd_side_t   in_side,
    output logic        out_valid,
    output logic [31:0] poly,
    output ncd_side_t   out_side
);

    logic        v0_reg;
    logic [30:0] k0_reg;
    ncd_side_t   s0_reg;

    logic               mv_reg [1:HORNER_STEPS];
    logic [62:0]        mp_reg [1:HORNER_STEPS];
    logic               mn_reg [1:HORNER_STEPS];
    logic [30:0]        mk_reg [1:HORNER_STEPS];
    ncd_side_t          ms_reg [1:HORNER_STEPS];
    logic               pv_reg [1:HORNER_STEPS];
    logic signed [32:0] p_reg  [1:HORNER_STEPS];
    logic [30:0]        pk_reg [1:HORNER_STEPS];
    ncd_side_t          ps_reg [1:HORNER_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg <= k30;
        s0_reg <= in_side;
    end

    for (genvar j = 1; j <= HORNER_STEPS; j++)
    begin : g_step
        logic               src_v;
        logic signed [32:0] src_p;
        logic [30:0]        src_k;
        ncd_side_t          src_s;
        logic [32:0]        mag;
        logic [63:0]        rsum;
        logic signed [32:0] rnd;
        logic signed [32:0] term;

        if (j == 1)
        begin : g_first
            assign src_v = v0_reg;
            assign src_p = A5_Q30;
            assign src_k = k0_reg;
            assign src_s = s0_reg;
        end
        else
        begin : g_rest
            assign src_v = pv_reg[j-1];
            assign src_p = p_reg[j-1];
            assign src_k = pk_reg[j-1];
            assign src_s = ps_reg[j-1];
        end

        assign mag  = src_p[32] ? 33'(-src_p) : 33'(src_p);
        assign rsum = {1'b0, mp_reg[j]} + (64'd1 << 29);
        assign rnd  = $signed(rsum[62:30]);
        assign term = mn_reg[j] ? -rnd : rnd;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[j] <= 1'b0;
                pv_reg[j] <= 1'b0;
            end
            else
            begin
                mv_reg[j] <= src_v;
                pv_reg[j] <= mv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            mp_reg[j] <= 63'(mag[31:0]) * 63'(src_k);
            mn_reg[j] <= src_p[32];
            mk_reg[j] <= src_k;
            ms_reg[j] <= src_s;
            p_reg[j]  <= HORNER_ADD[j] + term;
            pk_reg[j] <= mk_reg[j];
            ps_reg[j] <= ms_reg[j];
        end
    end

    // clamp a negative polynomial to zero
    assign out_valid = pv_reg[HORNER_STEPS];
    assign poly      = p_reg[HORNER_STEPS][32] ? 32'd0 : p_reg[HORNER_STEPS][31:0];
    assign out_side  = ps_reg[HORNER_STEPS];

endmodule

>>> design/ncd_exp.sv
// exp(-L^2/2): range reduction by ln 2, 13-term Horner series, final rounded shift.
module ncd_exp import ncd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] poly,
    input  ncd_side_t   in_side,
    output logic        out_valid,
    output logic [32:0] e,
    output logic [31:0] out_poly,
    output ncd_side_t   out_side
);

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [31:0] pl0_reg, pl1_reg, pl2_reg, pl3_reg, pl4_reg, pl5_reg, pl6_reg;
    ncd_side_t   s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic [57:0] sq1_reg;
    logic [36:0] t2_reg, t3_reg, t4_reg;
    logic [45:0] est3_reg;
    logic [5:0]  n4_reg, n5_reg, n6_reg;
    logic [37:0] nl4_reg;
    logic [32:0] r5_reg;
    logic [31:0] r6_reg;
    logic [57:0] tsum;
    logic [37:0] rdiff;
    logic [33:0] rsub;
    logic        rge;

    logic        av_reg [0:EXP_TERMS-1];
    logic [64:0] ars_reg [0:EXP_TERMS-1];
    logic [31:0] ar_reg [0:EXP_TERMS-1];
    logic [5:0]  an_reg [0:EXP_TERMS-1];
    logic [31:0] ap_reg [0:EXP_TERMS-1];
    ncd_side_t   as_reg [0:EXP_TERMS-1];
    logic        bv_reg [0:EXP_TERMS-1];
    logic [33:0] bm_reg [0:EXP_TERMS-1];
    logic [67:0] bmr_reg [0:EXP_TERMS-1];
    logic [31:0] br_reg [0:EXP_TERMS-1];
    logic [5:0]  bn_reg [0:EXP_TERMS-1];
    logic [31:0] bp_reg [0:EXP_TERMS-1];
    ncd_side_t   bs_reg [0:EXP_TERMS-1];
    logic        cv_reg [0:EXP_TERMS-1];
    logic [32:0] cs_reg [0:EXP_TERMS-1];
    logic [31:0] cr_reg [0:EXP_TERMS-1];
    logic [5:0]  cn_reg [0:EXP_TERMS-1];
    logic [31:0] cp_reg [0:EXP_TERMS-1];
    ncd_side_t   csd_reg [0:EXP_TERMS-1];

    logic        ov_reg;
    logic [32:0] e_reg;
    logic [31:0] op_reg;
    ncd_side_t   os_reg;
    logic [32:0] fin_s;
    logic [5:0]  fin_n;
    logic [63:0] fin_sum;
    logic [32:0] e_next;

    assign tsum  = sq1_reg + (58'd1 << 20);
    assign rdiff = {1'b0, t4_reg} - nl4_reg;
    assign rsub  = {1'b0, r5_reg} - {2'b00, LN2_Q32};
    assign rge   = !rsub[33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            ov_reg <= cv_reg[EXP_TERMS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        pl0_reg  <= poly;
        s0_reg   <= in_side;
        sq1_reg  <= 58'(s0_reg.mag) * 58'(s0_reg.mag);
        pl1_reg  <= pl0_reg;
        s1_reg   <= s0_reg;
        t2_reg   <= tsum[57:21];
        pl2_reg  <= pl1_reg;
        s2_reg   <= s1_reg;
        // quotient estimate by reciprocal, low by at most one
        est3_reg <= 46'(t2_reg[36:16]) * 46'(NDIV_M);
        t3_reg   <= t2_reg;
        pl3_reg  <= pl2_reg;
        s3_reg   <= s2_reg;
        n4_reg   <= est3_reg[45:40];
        nl4_reg  <= 38'(est3_reg[45:40]) * 38'(LN2_Q32);
        t4_reg   <= t3_reg;
        pl4_reg  <= pl3_reg;
        s4_reg   <= s3_reg;
        r5_reg   <= rdiff[32:0];
        n5_reg   <= n4_reg;
        pl5_reg  <= pl4_reg;
        s5_reg   <= s4_reg;
        r6_reg   <= rge ? rsub[31:0] : r5_reg[31:0];
        n6_reg   <= n5_reg + 6'(rge);
        pl6_reg  <= pl5_reg;
        s6_reg   <= s5_reg;
    end

    for (genvar i = 0; i < EXP_TERMS; i++)
    begin : g_term
        localparam int unsigned KD = EXP_TERMS - i;
        localparam logic [33:0] KW = 34'(KD);
        localparam logic [33:0] KH = 34'(KD / 2);
        localparam logic [33:0] KR = EXP_RECIP_FULL[KD][33:0];

        logic        src_v;
        logic [32:0] src_s;
        logic [31:0] src_r;
        logic [5:0]  src_n;
        logic [31:0] src_p;
        ncd_side_t   src_sd;
        logic [65:0] prnd;
        logic [33:0] m;
        logic [33:0] q0;
        logic [33:0] rem;
        logic [33:0] q;

        if (i == 0)
        begin : g_first
            assign src_v  = v6_reg;
            assign src_s  = ONE_Q32;
            assign src_r  = r6_reg;
            assign src_n  = n6_reg;
            assign src_p  = pl6_reg;
            assign src_sd = s6_reg;
        end
        else
        begin : g_rest
            assign src_v  = cv_reg[i-1];
            assign src_s  = cs_reg[i-1];
            assign src_r  = cr_reg[i-1];
            assign src_n  = cn_reg[i-1];
            assign src_p  = cp_reg[i-1];
            assign src_sd = csd_reg[i-1];
        end

        assign prnd = {1'b0, ars_reg[i]} + (66'd1 << 31);
        assign m    = prnd[65:32] + KH;
        // one correction step after the reciprocal multiply
        assign q0   = bmr_reg[i][66:33];
        assign rem  = bm_reg[i] - 34'(q0 * KW);
        assign q    = (rem >= KW) ? q0 + 34'd1 : q0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                av_reg[i] <= 1'b0;
                bv_reg[i] <= 1'b0;
                cv_reg[i] <= 1'b0;
            end
            else
            begin
                av_reg[i] <= src_v;
                bv_reg[i] <= av_reg[i];
                cv_reg[i] <= bv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            ars_reg[i] <= 65'(src_r) * 65'(src_s);
            ar_reg[i]  <= src_r;
            an_reg[i]  <= src_n;
            ap_reg[i]  <= src_p;
            as_reg[i]  <= src_sd;
            bm_reg[i]  <= m;
            bmr_reg[i] <= 68'(m) * 68'(KR);
            br_reg[i]  <= ar_reg[i];
            bn_reg[i]  <= an_reg[i];
            bp_reg[i]  <= ap_reg[i];
            bs_reg[i]  <= as_reg[i];
            cs_reg[i]  <= (q >= {1'b0, ONE_Q32}) ? 33'd0 : ONE_Q32 - q[32:0];
            cr_reg[i]  <= br_reg[i];
            cn_reg[i]  <= bn_reg[i];
            cp_reg[i]  <= bp_reg[i];
            csd_reg[i] <= bs_reg[i];
        end
    end

    assign fin_s   = cs_reg[EXP_TERMS-1];
    assign fin_n   = cn_reg[EXP_TERMS-1];
    assign fin_sum = 64'(fin_s) + ((64'd1 << fin_n) >> 1);

    always_comb
    begin
        if (fin_n == 6'd63)
        begin
            e_next = 33'd0;
        end
        else if (fin_n == 6'd0)
        begin
            e_next = fin_s;
        end
        else
        begin
            e_next = 33'(fin_sum >> fin_n);
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg  <= e_next;
        op_reg <= cp_reg[EXP_TERMS-1];
        os_reg <= csd_reg[EXP_TERMS-1];
    end

    assign out_valid = ov_reg;
    assign e         = e_reg;
    assign out_poly  = op_reg;
    assign out_side  = os_reg;

endmodule

>>> design/normal_cdf_approx.sv
// Top level: standard normal CDF pipeline, Q5.26 argument in, Q0.32 probability out.
// Takes one argument per clock and returns its probability on probability with done high
// for one cycle; busy stays low, results come out in input order and must be taken when
// shown. The depth is set by the 31-step reciprocal quotient, the five Horner steps and
// the 13-term exponential series, each a chain of registered stages. Arguments of
// magnitude 8.0 or more give 0 or all ones directly.
module normal_cdf_approx import ncd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x,
    output logic               done,
    output logic [31:0]        probability
);

    logic        rc_valid;
    logic [30:0] rc_k30;
    ncd_side_t   rc_side;
    logic        pl_valid;
    logic [31:0] pl_poly;
    ncd_side_t   pl_side;
    logic        ex_valid;
    logic [32:0] ex_e;
    logic [31:0] ex_poly;
    ncd_side_t   ex_side;

    logic        v1_reg, v2_reg, v3_reg, done_reg;
    logic [64:0] ph1_reg;
    logic [31:0] phi2_reg;
    logic [63:0] tp3_reg;
    logic [31:0] pl1_reg, pl2_reg;
    ncd_side_t   s1_reg, s2_reg, s3_reg;
    logic [31:0] prob_reg;
    logic [65:0] phsum;
    logic [64:0] tsum;
    logic [32:0] tail;
    logic [32:0] res;
    logic [31:0] prob_next;

    assign busy = 1'b0;

    ncd_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .x         (x),
        .out_valid (rc_valid),
        .k30       (rc_k30),
        .out_side  (rc_side)
    );

    ncd_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rc_valid),
        .k30       (rc_k30),
        .in_side   (rc_side),
        .out_valid (pl_valid),
        .poly      (pl_poly),
        .out_side  (pl_side)
    );

    ncd_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pl_valid),
        .poly      (pl_poly),
        .in_side   (pl_side),
        .out_valid (ex_valid),
        .e         (ex_e),
        .out_poly  (ex_poly),
        .out_side  (ex_side)
    );

    assign phsum = {1'b0, ph1_reg} + (66'd1 << 31);
    assign tsum  = {1'b0, tp3_reg} + (65'd1 << 29);

    always_comb
    begin
        tail = (tsum[64:30] > 35'(ONE_Q32)) ? ONE_Q32 : tsum[62:30];
        if (s3_reg.far)
        begin
            tail = 33'd0;
        end
        res = s3_reg.neg ? tail : ONE_Q32 - tail;
        // saturate 1.0 to the largest code
        prob_next = res[32] ? 32'hFFFF_FFFF : res[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ex_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ph1_reg  <= 65'(INVSQRT2PI_Q32) * 65'(ex_e);
        pl1_reg  <= ex_poly;
        s1_reg   <= ex_side;
        phi2_reg <= phsum[63:32];
        pl2_reg  <= pl1_reg;
        s2_reg   <= s1_reg;
        tp3_reg  <= 64'(phi2_reg) * 64'(pl2_reg);
        s3_reg   <= s2_reg;
        prob_reg <= prob_next;
    end

    assign done        = done_reg;
    assign probability = prob_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##NCD_LAT done)
        else $error("accepted beat did not come out after the pipeline depth");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NCD_LAT))
        else $error("result beat without a matching input beat");

    a_far_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !x[31] && (x[30:29] != 2'b00)) |-> ##NCD_LAT (probability == 32'hFFFF_FFFF))
        else $error("large positive argument did not saturate");

    a_far_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (start && x[31] && (x[30:29] != 2'b11)) |-> ##NCD_LAT (probability == 32'd0))
        else $error("large negative argument did not give zero");

endmodule
